// ===== src/touch_click_hold_detector_core_macros.svh =====
// ----------------------------------------------------------------------------
// touch click hold detector assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef TOUCH_CLICK_HOLD_DETECTOR_CORE_MACROS_SVH
`define TOUCH_CLICK_HOLD_DETECTOR_CORE_MACROS_SVH

// condition implies consequence in the same cycle
`define TCHD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define TCHD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// reset behavior, checked also while reset is asserted
`define TCHD_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/tchd_pkg.sv =====
// ----------------------------------------------------------------------------
// tchd_pkg
// types and constants of the touch click hold detector
// ----------------------------------------------------------------------------
package tchd_pkg;

  localparam int ITEM_DATA_W = 48;
  localparam int ITEM_USER_W = 2;
  localparam int RES_DATA_W  = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_ACK    = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;
  localparam logic [1:0] ACT_STEP   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLICK_GAP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP      = 2'd3;

  localparam logic [15:0] DEBOUNCE_RST  = 16'd80;
  localparam logic [15:0] HOLD_RST      = 16'd500;
  localparam logic [15:0] CLICK_GAP_RST = 16'd300;
  localparam logic [15:0] STEP_RST      = 16'd400;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] hold_ms;
    logic [15:0] click_gap_ms;
    logic [15:0] step_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic        touch_level;
    logic [31:0] now_ms;
    logic [7:0]  step_clicks;
    logic [3:0]  ack_mask;
  } item_t;

  typedef struct packed {
    logic holdlatch;
    logic pendclick;
    logic consume;
    logic ready;
    logic step;
    logic holded;
    logic touched_one;
    logic released;
    logic deb;
    logic accepted;
  } status_t;

  typedef struct packed {
    logic       released_event;
    logic       touch_event;
    logic       holded_event;
    logic       holding;
    logic       clicks_ready;
    logic [7:0] click_count;
    logic [7:0] hold_click_count;
    logic       step_due;
  } result_t;

endpackage

// ===== src/touch_click_hold_detector_core.sv =====
// ----------------------------------------------------------------------------
// touch_click_hold_detector_core
// touch qualifier turning timestamped samples into click, hold and step events
// ----------------------------------------------------------------------------
// Takes one request per clock cycle unless the result output is stalled, and
// returns exactly one result for each, in order. A request passes an input
// register, is evaluated against the detector state in a single combinational
// pass, and lands in the result register, so its result is shown in the cycle
// after it is taken. The detector state updates in the cycle it is taken, which
// lets back-to-back requests see each other's effects.
// Configuration registers are always ready and should be written only while
// no request is in flight.
module touch_click_hold_detector_core (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: touch_level, now_ms, step_clicks, ack_mask, zero fill
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tchd_pkg::ITEM_DATA_W-1:0] in_tdata,
  // in_tuser: action
  input  logic [tchd_pkg::ITEM_USER_W-1:0] in_tuser,
  // out_tdata: released_event, touch_event, holded_event, holding,
  // clicks_ready, click_count, hold_click_count, step_due, zero fill
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tchd_pkg::RES_DATA_W-1:0]  out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tchd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tchd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tchd_pkg::*;

  cfg_t                  cfg_r;
  item_t                 item;
  result_t               res;
  logic                  item_valid;
  logic                  take;
  logic                  out_valid_r;
  logic [RES_DATA_W-1:0] out_data_r;

  assign take      = item_valid && (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;

  tchd_ingress u_ingress (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  tchd_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (take),
    .item  (item),
    .cfg   (cfg_r),
    .res   (res)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms  <= DEBOUNCE_RST;
      cfg_r.hold_ms      <= HOLD_RST;
      cfg_r.click_gap_ms <= CLICK_GAP_RST;
      cfg_r.step_ms      <= STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEBOUNCE:  cfg_r.debounce_ms  <= cfg_data;
        REG_HOLD:      cfg_r.hold_ms      <= cfg_data;
        REG_CLICK_GAP: cfg_r.click_gap_ms <= cfg_data;
        REG_STEP:      cfg_r.step_ms      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= {2'b00, res.step_due, res.hold_click_count, res.click_count,
                     res.clicks_ready, res.holding, res.holded_event,
                     res.touch_event, res.released_event};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== src/tchd_ingress.sv =====
// ----------------------------------------------------------------------------
// tchd_ingress
// input register: captures one request and unpacks its fields
// ----------------------------------------------------------------------------
module tchd_ingress (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tchd_pkg::ITEM_DATA_W-1:0] in_tdata,
  input  logic [tchd_pkg::ITEM_USER_W-1:0] in_tuser,
  input  logic                             take,
  output logic                             item_valid,
  output tchd_pkg::item_t                  item
);
  import tchd_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign in_tready  = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.action      <= in_tuser;
      item_r.touch_level <= in_tdata[0];
      item_r.now_ms      <= in_tdata[32:1];
      item_r.step_clicks <= in_tdata[40:33];
      item_r.ack_mask    <= in_tdata[44:41];
    end
  end

endmodule

// ===== src/tchd_engine.sv =====
// ----------------------------------------------------------------------------
// tchd_engine
// detector state and the single-pass update for one request
// ----------------------------------------------------------------------------
module tchd_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  tchd_pkg::item_t   item,
  input  tchd_pkg::cfg_t    cfg,
  output tchd_pkg::result_t res
);
  import tchd_pkg::*;

  status_t     st_r, st_nxt, emit_st;
  logic [31:0] timer_r, timer_nxt;
  logic [7:0]  run_r, run_nxt;
  logic [7:0]  fin_r, fin_nxt;
  logic [7:0]  cbh_r, cbh_nxt;
  logic        due;

  always_comb begin
    st_nxt    = st_r;
    timer_nxt = timer_r;
    run_nxt   = run_r;
    fin_nxt   = fin_r;
    cbh_nxt   = cbh_r;
    due       = 1'b0;
    emit_st   = st_r;
    unique case (item.action)
      ACT_SAMPLE: begin
        // debounce
        if (item.touch_level && !st_nxt.accepted) begin
          if (!st_nxt.deb) begin
            st_nxt.deb = 1'b1;
            timer_nxt  = item.now_ms;
          end else if ((item.now_ms - timer_nxt) >= {16'd0, cfg.debounce_ms}) begin
            st_nxt.accepted  = 1'b1;
            st_nxt.pendclick = 1'b1;
          end
        end else begin
          st_nxt.deb = 1'b0;
        end
        // release
        if (!item.touch_level && st_nxt.accepted) begin
          st_nxt.accepted = 1'b0;
          if (!st_nxt.holdlatch) begin
            run_nxt = run_nxt + 8'd1;
          end
          st_nxt.holdlatch = 1'b0;
          st_nxt.released  = 1'b1;
          timer_nxt        = item.now_ms;
          if (st_nxt.step) begin
            fin_nxt     = 8'd0;
            run_nxt     = 8'd0;
            st_nxt.step = 1'b0;
          end
          if (st_nxt.pendclick) begin
            st_nxt.pendclick   = 1'b0;
            st_nxt.touched_one = 1'b1;
          end
        end
        // hold threshold
        if (st_nxt.accepted && item.touch_level && !st_nxt.holdlatch &&
            (item.now_ms - timer_nxt) >= {16'd0, cfg.hold_ms}) begin
          st_nxt.holdlatch = 1'b1;
          cbh_nxt          = run_nxt;
          st_nxt.holded    = 1'b1;
          st_nxt.step      = 1'b1;
          st_nxt.pendclick = 1'b0;
          timer_nxt        = item.now_ms;
        end
        // click series timeout
        if (!item.touch_level && run_nxt != 8'd0 &&
            (item.now_ms - timer_nxt) >= {16'd0, cfg.click_gap_ms}) begin
          fin_nxt      = run_nxt;
          run_nxt      = 8'd0;
          st_nxt.ready = 1'b1;
        end
        // deferred consume
        if (st_nxt.consume) begin
          fin_nxt        = 8'd0;
          st_nxt.ready   = 1'b0;
          st_nxt.consume = 1'b0;
        end
        emit_st = st_nxt;
      end
      ACT_ACK: begin
        if (item.ack_mask[0]) st_nxt.released    = 1'b0;
        if (item.ack_mask[1]) st_nxt.touched_one = 1'b0;
        if (item.ack_mask[2]) st_nxt.holded      = 1'b0;
        if (item.ack_mask[3]) st_nxt.consume     = 1'b1;
        emit_st = st_r;
      end
      ACT_CLEAR: begin
        st_nxt.released    = 1'b0;
        st_nxt.touched_one = 1'b0;
        st_nxt.holded      = 1'b0;
        st_nxt.step        = 1'b0;
        st_nxt.ready       = 1'b0;
        cbh_nxt            = 8'd0;
        fin_nxt            = 8'd0;
        emit_st            = st_nxt;
      end
      ACT_STEP: begin
        if (run_r == item.step_clicks && st_r.step &&
            (item.now_ms - timer_r) >= {16'd0, cfg.step_ms}) begin
          timer_nxt = item.now_ms;
          due       = 1'b1;
        end
        emit_st = st_nxt;
      end
      default: begin
        emit_st = st_r;
      end
    endcase
  end

  assign res.released_event   = emit_st.released;
  assign res.touch_event      = emit_st.touched_one;
  assign res.holded_event     = emit_st.holded;
  assign res.holding          = emit_st.step;
  assign res.clicks_ready     = emit_st.ready;
  assign res.click_count      = fin_nxt;
  assign res.hold_click_count = cbh_nxt;
  assign res.step_due         = due;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= '0;
      timer_r <= 32'd0;
      run_r   <= 8'd0;
      fin_r   <= 8'd0;
      cbh_r   <= 8'd0;
    end else if (fire) begin
      st_r    <= st_nxt;
      timer_r <= timer_nxt;
      run_r   <= run_nxt;
      fin_r   <= fin_nxt;
      cbh_r   <= cbh_nxt;
    end
  end

endmodule

// ===== src/tchd_checker.sv =====
// ----------------------------------------------------------------------------
// tchd_checker
// port-level checks on the touch click hold detector
// ----------------------------------------------------------------------------
`include "touch_click_hold_detector_core_macros.svh"

module tchd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tchd_pkg::RES_DATA_W-1:0]  out_tdata,
  input logic                             cfg_ready
);
  import tchd_pkg::*;

  `TCHD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `TCHD_ASSERT_RST(a_rst_empty, !rst_n, !out_tvalid, "result valid right after reset")
  `TCHD_ASSERT_NOW(a_step_holding, out_tvalid && out_tdata[21], out_tdata[3], "step tick outside step mode")
  `TCHD_ASSERT_NOW(a_fill_zero, out_tvalid, out_tdata[23:22] == 2'b00, "result fill bits set")
  `TCHD_ASSERT_NOW(a_cfg_ready, rst_n, cfg_ready, "configuration port not ready")

endmodule

bind touch_click_hold_detector_core tchd_checker u_tchd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_ready  (cfg_ready)
);
